FILE: rtl/hslrgb_pkg.sv
// Shared widths and constants for the HSL to RGB converter.
package hslrgb_pkg;

	localparam int HUE_W = 24;
	localparam int SAT_W = 18;
	localparam int LIT_W = 17;
	localparam int CH_W  = 8;

	localparam logic [CH_W-1:0] FULL_SCALE_RESET = 8'd255;

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter: seven-stage pipeline, one triple per clock.
//
// Takes one hue/saturation/lightness item per clock (busy is always low) and
// shows red/green/blue with a one-cycle done strobe when the item leaves the
// last stage. The receiver cannot stall the block: each result must be
// taken in its strobe cycle. The seven stages are the input clamp, three
// multiplier stages (lightness/saturation product, hue ramp product,
// full-scale product), the v1/v2 and ramp weight stage, the channel level sum
// and the final round-and-saturate stage. full_scale is read live by the last
// two stages and must only be written while no item is in flight.
module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  full_scale_we,
	input  logic [hslrgb_pkg::CH_W-1:0]           full_scale_wdata,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [hslrgb_pkg::HUE_W-1:0]   hue,
	input  logic signed [hslrgb_pkg::SAT_W-1:0]   saturation,
	input  logic [hslrgb_pkg::LIT_W-1:0]          lightness,
	output logic                                  done,
	output logic [hslrgb_pkg::CH_W-1:0]           red,
	output logic [hslrgb_pkg::CH_W-1:0]           green,
	output logic [hslrgb_pkg::CH_W-1:0]           blue
);

	localparam int F     = FRAC_BITS;
	localparam int LW    = hslrgb_pkg::LIT_W;
	localparam int CW    = hslrgb_pkg::CH_W;
	localparam int ONE   = 1 << F;
	localparam int HALF  = 1 << (F - 1);
	localparam int HX    = (F + 2 > hslrgb_pkg::HUE_W) ? F + 2 : hslrgb_pkg::HUE_W;
	localparam int SX    = (F + 2 > hslrgb_pkg::SAT_W) ? F + 2 : hslrgb_pkg::SAT_W;
	localparam int UW    = F + 1;
	localparam int MW    = F + 2;
	localparam int PW    = LW + MW;
	localparam int TW    = F + 2;
	localparam int XW    = F + 4;
	localparam int VW    = ((LW > F + 1) ? LW : F + 1) + 2;
	localparam int DW    = VW + 1;
	localparam int KW    = UW + 1;
	localparam int RW    = DW + KW;
	localparam int NW    = RW + 1;
	localparam int QW    = NW + CW + 1;

	localparam logic signed [HX-1:0] ONE_H   = HX'(ONE);
	localparam logic signed [SX-1:0] ONE_S   = SX'(ONE);
	localparam logic signed [XW-1:0] ONE_X   = XW'(ONE);
	localparam logic signed [XW-1:0] TWO_X   = XW'(2 * ONE);
	localparam logic signed [XW-1:0] THREE_X = XW'(3 * ONE);
	localparam logic signed [XW-1:0] FOUR_X  = XW'(4 * ONE);
	localparam logic [QW-1:0]        RND     = QW'(1) << (2 * F - 1);

	function automatic logic [UW-1:0] hue_k(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] xw;
		logic signed [XW-1:0] x2;
		logic signed [XW-1:0] kk;
		xw = x;
		if (xw < 0) begin
			xw = xw + THREE_X;
		end else if (xw > THREE_X) begin
			xw = xw - THREE_X;
		end
		x2 = xw <<< 1;
		if (x2 < ONE_X) begin
			kk = x2;
		end else if (x2 < THREE_X) begin
			kk = ONE_X;
		end else if (xw < TWO_X) begin
			kk = FOUR_X - x2;
		end else begin
			kk = '0;
		end
		return kk[UW-1:0];
	endfunction

	logic [CW-1:0] full_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= hslrgb_pkg::FULL_SCALE_RESET;
		end else if (full_scale_we) begin
			full_scale_q <= full_scale_wdata;
		end
	end

	assign busy = 1'b0;

	// stage 0: clamp saturation, clamp negative hue to zero and wrap hue above one
	logic signed [HX-1:0] hue_x;
	logic signed [SX-1:0] sat_x;
	logic [UW-1:0]        h_c;
	logic [UW-1:0]        s_c;

	always_comb begin
		hue_x = HX'(hue);
		sat_x = SX'(saturation);
		if (hue_x < 0) begin
			h_c = '0;
		end else if (hue_x > ONE_H) begin
			if (hue_x[F-1:0] == '0) begin
				h_c = UW'(ONE);
			end else begin
				h_c = {1'b0, hue_x[F-1:0]};
			end
		end else begin
			h_c = hue_x[F:0];
		end
		if (sat_x < 0) begin
			s_c = '0;
		end else if (sat_x > ONE_S) begin
			s_c = UW'(ONE);
		end else begin
			s_c = sat_x[F:0];
		end
	end

	logic          vld_s1;
	logic [UW-1:0] h_s1;
	logic [UW-1:0] s_s1;
	logic [LW-1:0] l_s1;
	logic          lo_s1;
	logic          grey_s1;

	always_ff @(posedge clk) begin
		h_s1    <= h_c;
		s_s1    <= s_c;
		l_s1    <= lightness;
		lo_s1   <= (32'(lightness) < 32'(HALF));
		grey_s1 <= (s_c == '0);
	end

	// stage 1: lightness product and 3*hue
	logic [MW-1:0] m_c;
	logic [PW-1:0] p_c;
	logic [TW-1:0] t_c;

	always_comb begin
		m_c = lo_s1 ? (MW'(ONE) + MW'(s_s1)) : MW'(s_s1);
		p_c = PW'(l_s1) * PW'(m_c);
		t_c = (TW'(h_s1) << 1) + TW'(h_s1);
	end

	logic          vld_s2;
	logic [PW-1:0] p_s2;
	logic [TW-1:0] t_s2;
	logic [UW-1:0] s_s2;
	logic [LW-1:0] l_s2;
	logic          lo_s2;
	logic          grey_s2;

	always_ff @(posedge clk) begin
		p_s2    <= p_c;
		t_s2    <= t_c;
		s_s2    <= s_s1;
		l_s2    <= l_s1;
		lo_s2   <= lo_s1;
		grey_s2 <= grey_s1;
	end

	// stage 2: v1, v2 and per-channel ramp weights
	logic [PW-F-1:0]      ph_c;
	logic signed [VW-1:0] v2_c;
	logic signed [VW-1:0] v1_c;
	logic signed [DW-1:0] dv_c;
	logic signed [XW-1:0] tx_c;
	logic [UW-1:0]        k_c [3];

	always_comb begin
		ph_c = p_s2[PW-1:F];
		if (lo_s2) begin
			v2_c = VW'(ph_c);
		end else begin
			v2_c = VW'(l_s2) + VW'(s_s2) - VW'(ph_c);
		end
		v1_c   = (VW'(l_s2) <<< 1) - v2_c;
		dv_c   = DW'(v2_c) - DW'(v1_c);
		tx_c   = XW'(t_s2);
		k_c[0] = hue_k(tx_c + ONE_X);
		k_c[1] = hue_k(tx_c);
		k_c[2] = hue_k(tx_c - ONE_X);
	end

	logic                 vld_s3;
	logic signed [VW-1:0] v1_s3;
	logic signed [DW-1:0] dv_s3;
	logic [UW-1:0]        k_s3 [3];
	logic [LW-1:0]        l_s3;
	logic                 grey_s3;

	always_ff @(posedge clk) begin
		v1_s3   <= v1_c;
		dv_s3   <= dv_c;
		k_s3    <= k_c;
		l_s3    <= l_s2;
		grey_s3 <= grey_s2;
	end

	// stage 3: ramp products
	logic signed [RW-1:0] prod_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod_c[c] = RW'(dv_s3) * RW'(signed'({1'b0, k_s3[c]}));
		end
	end

	logic                 vld_s4;
	logic signed [VW-1:0] v1_s4;
	logic signed [RW-1:0] prod_s4 [3];
	logic [LW-1:0]        l_s4;
	logic                 grey_s4;

	always_ff @(posedge clk) begin
		v1_s4   <= v1_s3;
		prod_s4 <= prod_c;
		l_s4    <= l_s3;
		grey_s4 <= grey_s3;
	end

	// stage 4: channel level, or lightness for grey
	logic signed [NW-1:0] n_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (grey_s4) begin
				n_c[c] = NW'(l_s4);
			end else begin
				n_c[c] = (NW'(v1_s4) <<< F) + NW'(prod_s4[c]);
			end
		end
	end

	logic                 vld_s5;
	logic signed [NW-1:0] n_s5 [3];
	logic                 grey_s5;

	always_ff @(posedge clk) begin
		n_s5    <= n_c;
		grey_s5 <= grey_s4;
	end

	// stage 5: full-scale products
	logic signed [QW-1:0] q_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			q_c[c] = QW'(n_s5[c]) * QW'(signed'({1'b0, full_scale_q}));
		end
	end

	logic                 vld_s6;
	logic signed [QW-1:0] q_s6 [3];
	logic                 grey_s6;

	always_ff @(posedge clk) begin
		q_s6    <= q_c;
		grey_s6 <= grey_s5;
	end

	// stage 6: round (grey truncates) and saturate
	logic [QW-1:0] r_c  [3];
	logic [CW-1:0] ch_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (q_s6[c] < 0) begin
				r_c[c] = '0;
			end else if (grey_s6) begin
				r_c[c] = QW'(q_s6[c]) >> F;
			end else begin
				r_c[c] = (QW'(q_s6[c]) + RND) >> (2 * F);
			end
			if (r_c[c] > QW'(full_scale_q)) begin
				ch_c[c] = full_scale_q;
			end else begin
				ch_c[c] = r_c[c][CW-1:0];
			end
		end
	end

	logic          done_s7;
	logic [CW-1:0] red_s7;
	logic [CW-1:0] green_s7;
	logic [CW-1:0] blue_s7;
	logic          grey_s7;

	always_ff @(posedge clk) begin
		red_s7   <= ch_c[0];
		green_s7 <= ch_c[1];
		blue_s7  <= ch_c[2];
		grey_s7  <= grey_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			done_s7 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			done_s7 <= vld_s6;
		end
	end

	assign done  = done_s7;
	assign red   = red_s7;
	assign green = green_s7;
	assign blue  = blue_s7;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("item accepted but no result seven cycles later");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red <= full_scale_q) && (green <= full_scale_q) && (blue <= full_scale_q))
		else $error("channel above full scale");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && grey_s7 |-> (red == green) && (green == blue))
		else $error("grey item with unequal channels");

endmodule

FILE: test/hsl_to_rgb_converter_tb.sv
// Self-checking testbench for hsl_to_rgb_converter: directed and random triples, scoreboard.
module hsl_to_rgb_converter_tb;

	localparam int HUE_W     = hslrgb_pkg::HUE_W;
	localparam int SAT_W     = hslrgb_pkg::SAT_W;
	localparam int LIT_W     = hslrgb_pkg::LIT_W;
	localparam int CH_W      = hslrgb_pkg::CH_W;
	localparam int FRAC_BITS = 16;
	localparam int LATENCY   = 7;
	localparam int LIMIT     = 200000;
	localparam int MAX_SHOWN = 20;

	typedef struct {
		logic        [CH_W-1:0]  red;
		logic        [CH_W-1:0]  green;
		logic        [CH_W-1:0]  blue;
		logic signed [HUE_W-1:0] hue;
		logic signed [SAT_W-1:0] sat;
		logic        [LIT_W-1:0] lit;
	} color_expect_t;

	class color_scoreboard;
		int            full_scale = hslrgb_pkg::FULL_SCALE_RESET;
		color_expect_t expected_colors[$];
		int            n_items;
		int            n_checked;
		int            n_errors;

		function int pending();
			return expected_colors.size();
		endfunction

		task report_mismatch(string what);
			if (n_errors < MAX_SHOWN)
				$display("mismatch at %0t: %s", $realtime, what);
			n_errors++;
		endtask

		// piecewise-linear hue ramp, x in thirds of a turn scaled by ONE
		function longint hue_ramp(longint v1, longint v2, longint x);
			longint one;
			one = longint'(1) << FRAC_BITS;
			if (x < 0)
				x += 3 * one;
			if (x > 3 * one)
				x -= 3 * one;
			if (2 * x < one)
				return v1 * one + (v2 - v1) * (2 * x);
			if (2 * x < 3 * one)
				return v2 * one;
			if (x < 2 * one)
				return v1 * one + (v2 - v1) * (4 * one - 2 * x);
			return v1 * one;
		endfunction

		function logic [CH_W-1:0] scale_channel(longint level);
			longint den, q, r;
			den = longint'(1) << (2 * FRAC_BITS);
			q = full_scale * level;
			if (q >= 0)
				r = (q + den / 2) / den;
			else
				r = -((-q + den / 2) / den);
			if (r < 0)
				r = 0;
			if (r > full_scale)
				r = full_scale;
			return CH_W'(r);
		endfunction

		task note_item(logic signed [HUE_W-1:0] hue_in, logic signed [SAT_W-1:0] sat_in,
				logic [LIT_W-1:0] lit_in);
			color_expect_t e;
			longint one, h, s, l, v1, v2, t, g;
			one = longint'(1) << FRAC_BITS;
			h = hue_in;
			s = sat_in;
			l = lit_in;
			e.hue = hue_in;
			e.sat = sat_in;
			e.lit = lit_in;
			if (h < 0)
				h = 0;
			else if (h > one) begin
				h = h & (one - 1);
				if (h == 0)
					h = one;
			end
			if (s < 0)
				s = 0;
			else if (s > one)
				s = one;
			if (s == 0) begin
				// grey: truncated, not rounded
				g = (l * full_scale) >> FRAC_BITS;
				if (g > full_scale)
					g = full_scale;
				e.red   = CH_W'(g);
				e.green = CH_W'(g);
				e.blue  = CH_W'(g);
			end else begin
				if (2 * l < one)
					v2 = (l * (one + s)) >> FRAC_BITS;
				else
					v2 = l + s - ((s * l) >> FRAC_BITS);
				v1 = 2 * l - v2;
				t = 3 * h;
				e.red   = scale_channel(hue_ramp(v1, v2, t + one));
				e.green = scale_channel(hue_ramp(v1, v2, t));
				e.blue  = scale_channel(hue_ramp(v1, v2, t - one));
			end
			expected_colors.push_back(e);
			n_items++;
		endtask

		task check_result(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			color_expect_t e;
			if (expected_colors.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d/%0d with no item pending", r, g, b));
				return;
			end
			e = expected_colors.pop_front();
			n_checked++;
			if (r !== e.red)
				report_mismatch($sformatf("red %0d, want %0d (hue %0d sat %0d lit %0d fs %0d)",
					r, e.red, e.hue, e.sat, e.lit, full_scale));
			if (g !== e.green)
				report_mismatch($sformatf("green %0d, want %0d (hue %0d sat %0d lit %0d fs %0d)",
					g, e.green, e.hue, e.sat, e.lit, full_scale));
			if (b !== e.blue)
				report_mismatch($sformatf("blue %0d, want %0d (hue %0d sat %0d lit %0d fs %0d)",
					b, e.blue, e.hue, e.sat, e.lit, full_scale));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    full_scale_we;
	logic [CH_W-1:0]         full_scale_wdata;
	logic                    start;
	logic                    busy;
	logic signed [HUE_W-1:0] hue;
	logic signed [SAT_W-1:0] saturation;
	logic [LIT_W-1:0]        lightness;
	logic                    done;
	logic [CH_W-1:0]         red;
	logic [CH_W-1:0]         green;
	logic [CH_W-1:0]         blue;

	color_scoreboard sb = new();
	int idle_pct;
	int cycles;

	hsl_to_rgb_converter #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.full_scale_we(full_scale_we),
		.full_scale_wdata(full_scale_wdata),
		.start(start),
		.busy(busy),
		.hue(hue),
		.saturation(saturation),
		.lightness(lightness),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_item(hue, saturation, lightness);
		if (arst_n && done)
			sb.check_result(red, green, blue);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
			$display("[hsl_to_rgb_converter] ERROR");
			$finish;
		end
	end

	task automatic send_item(logic signed [HUE_W-1:0] h, logic signed [SAT_W-1:0] s,
			logic [LIT_W-1:0] l);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start      <= 1'b1;
		hue        <= h;
		saturation <= s;
		lightness  <= l;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (LATENCY + 3) @(negedge clk);
	endtask

	task automatic write_full_scale(logic [CH_W-1:0] value);
		wait_drained();
		@(negedge clk);
		full_scale_we    <= 1'b1;
		full_scale_wdata <= value;
		@(negedge clk);
		full_scale_we <= 1'b0;
		sb.full_scale = value;
	endtask

	task automatic send_random_item();
		logic signed [HUE_W-1:0] h;
		logic signed [SAT_W-1:0] s;
		logic [LIT_W-1:0]        l;
		case ($urandom_range(9))
			0: h = HUE_W'($urandom);
			1: h = HUE_W'($urandom_range(4) * 65536);
			2: h = HUE_W'($urandom_range(131072));
			default: h = HUE_W'($urandom_range(65536));
		endcase
		case ($urandom_range(9))
			0: s = SAT_W'($urandom);
			1: s = '0;
			2: s = SAT_W'(65536);
			default: s = SAT_W'($urandom_range(65536));
		endcase
		case ($urandom_range(9))
			0: l = LIT_W'($urandom);
			1: l = $urandom_range(1) ? LIT_W'(65536) : '0;
			default: l = LIT_W'($urandom_range(65536));
		endcase
		send_item(h, s, l);
	endtask

	task automatic random_phase(int n);
		repeat (n) begin
			send_random_item();
			if ($urandom_range(299) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		full_scale_we    = 1'b0;
		full_scale_wdata = '0;
		start            = 1'b0;
		hue              = '0;
		saturation       = '0;
		lightness        = '0;
		idle_pct         = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, full_scale at its reset value
		send_item(24'sd0, 18'sd65536, 17'd32768);
		send_item(24'sd10923, 18'sd65536, 17'd32768);
		send_item(24'sd21845, 18'sd65536, 17'd32768);
		send_item(24'sd32768, 18'sd65536, 17'd32768);
		send_item(24'sd43691, 18'sd65536, 17'd32768);
		send_item(24'sd54613, 18'sd65536, 17'd32768);
		send_item(24'sd65536, 18'sd65536, 17'd32768);
		send_item(24'sh800000, 18'sd40000, 17'd20000);
		send_item(-24'sd1, 18'sd40000, 17'd50000);
		send_item(24'sd8388607, 18'sd65536, 17'd32768);
		send_item(24'sd131072, 18'sd65536, 17'd32768);
		send_item(24'sd65537, 18'sd30000, 17'd40000);
		send_item(24'sd5000, 18'sh20000, 17'd45000);
		send_item(24'sd5000, -18'sd1, 17'd65536);
		send_item(24'sd5000, 18'sd131071, 17'd30000);
		send_item(24'sd5000, 18'sd1, 17'd32767);
		send_item(24'sd30000, 18'sd0, 17'd0);
		send_item(24'sd30000, 18'sd0, 17'd65535);
		send_item(24'sd30000, 18'sd0, 17'd131071);
		send_item(24'sd20000, 18'sd65536, 17'd0);
		send_item(24'sd20000, 18'sd65536, 17'd65536);
		send_item(24'sd20000, 18'sd50000, 17'd131071);
		send_item(24'sd20000, 18'sd50000, 17'd32767);
		send_item(24'sd8388607, 18'sh20000, 17'd131071);

		write_full_scale(8'd0);
		random_phase(100);
		write_full_scale(8'd1);
		random_phase(100);

		idle_pct = 8;
		write_full_scale(CH_W'($urandom_range(2, 254)));
		random_phase(450);

		idle_pct = 45;
		write_full_scale(8'd128);
		random_phase(450);

		idle_pct = 0;
		write_full_scale(8'd255);
		random_phase(450);

		wait_drained();
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d expected results never came", sb.pending()));
		$display("Ran %0d triples: directed hue/saturation/lightness extremes, then random mixes",
			sb.n_items);
		$display("with full_scale 255, 0, 1, random and 128; %0d results compared, %0d mismatches",
			sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0)
			$display("[hsl_to_rgb_converter] OK");
		else
			$display("[hsl_to_rgb_converter] ERROR");
		$finish;
	end

endmodule
